FILE: hw/rtl/pat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pat_pkg
// Shared constants and types of the program association section parser.
// ----------------------------------------------------------------------------
package pat_pkg;

  localparam int SECTION_SLOTS = 256;
  localparam int SLOT_W        = (SECTION_SLOTS > 1) ? $clog2(SECTION_SLOTS) : 1;

  typedef enum logic [2:0] {
    KIND_ENTRY    = 3'd0,
    KIND_ACCEPTED = 3'd1,
    KIND_REPEAT   = 3'd2,
    KIND_UPDATE   = 3'd3,
    KIND_INVALID  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] program_number;
    logic [12:0] map_pid;
    logic [15:0] stream_id;
    logic [4:0]  version;
    logic [7:0]  section_number;
    logic [15:0] received_count;
    logic        last;
  } result_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_slot;
    logic [SLOT_W-1:0] query_slot;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
    logic [4:0]        wr_version;
    logic [31:0]       wr_crc;
  } store_req_t;

  typedef struct packed {
    logic        present;
    logic [4:0]  version;
    logic [31:0] crc;
  } store_rsp_t;

endpackage
`default_nettype wire

FILE: hw/rtl/pat_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pat_if
// Handshake channels: section bytes, parse results and register writes.
// ----------------------------------------------------------------------------
interface pat_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;
  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface pat_result_if;
  logic                 valid;
  logic                 ready;
  pat_pkg::kind_t       kind;
  logic [15:0]          program_number;
  logic [12:0]          map_pid;
  logic [15:0]          stream_id;
  logic [4:0]           version;
  logic [7:0]           section_number;
  logic [15:0]          received_count;
  logic                 last;
  modport source (output valid, kind, program_number, map_pid, stream_id, version,
                  section_number, received_count, last, input ready);
  modport sink (input valid, kind, program_number, map_pid, stream_id, version,
                section_number, received_count, last, output ready);
endinterface

interface pat_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/pat_slot_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pat_slot_store
// Per-section record: presence flags in flops, version and CRC in a memory.
// ----------------------------------------------------------------------------
module pat_slot_store (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pat_pkg::store_req_t req,
  output pat_pkg::store_rsp_t      rsp
);

  logic [pat_pkg::SECTION_SLOTS-1:0] present;
  logic [36:0]                       mem [pat_pkg::SECTION_SLOTS];
  logic [36:0]                       rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
    end else if (req.wr_en) begin
      present[req.wr_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_slot] <= {req.wr_version, req.wr_crc};
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_slot];
    end
  end

  assign rsp.present = present[req.query_slot];
  assign rsp.version = rd_data[36:32];
  assign rsp.crc     = rd_data[31:0];

endmodule
`default_nettype wire

FILE: hw/rtl/pat_parse_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pat_parse_core
// Section byte decoder: header capture, entry assembly, status decision.
// ----------------------------------------------------------------------------
module pat_parse_core (
  input  wire logic                clk,
  input  wire logic                rst,
  pat_cfg_if.sink                  cfg,
  input  wire logic                fire,
  input  wire logic [7:0]          data_byte,
  input  wire logic                first_byte,
  input  wire logic                last_byte,
  output pat_pkg::store_req_t      req,
  input  wire pat_pkg::store_rsp_t rsp,
  output logic [1:0]               res_cnt,
  output pat_pkg::result_t         res0,
  output pat_pkg::result_t         res1
);

  localparam logic [12:0] POS_TABLE_ID = 13'd0;
  localparam logic [12:0] POS_LEN_HI   = 13'd1;
  localparam logic [12:0] POS_LEN_LO   = 13'd2;
  localparam logic [12:0] POS_SID_HI   = 13'd3;
  localparam logic [12:0] POS_SID_LO   = 13'd4;
  localparam logic [12:0] POS_VERSION  = 13'd5;
  localparam logic [12:0] POS_SECTION  = 13'd6;
  localparam logic [12:0] POS_RESERVED = 13'd7;

  typedef enum logic {
    MODE_IDLE,
    MODE_ACTIVE
  } mode_t;

  mode_t       mode, mode_next;
  logic [7:0]  expected_table_id;
  logic [12:0] byte_index, byte_index_next, idx_c;
  logic [12:0] total_length, total_length_next, tl_c;
  logic [15:0] stream_id, stream_id_next;
  logic [4:0]  version, version_next;
  logic [7:0]  section_number, section_number_next;
  logic [23:0] entry_shift, entry_shift_next;
  logic [31:0] crc_shift, crc_shift_next;
  logic [15:0] accepted_count, accepted_count_next;
  logic [12:0] entry_end;
  logic        active;
  logic        bad, done, entry_hit, tail_valid;
  pat_pkg::kind_t tail_kind;
  logic [15:0] entry_prog;
  logic [12:0] entry_pid;
  logic        slot_ok;

  assign cfg.ready = 1'b1;

  function automatic pat_pkg::result_t make_res(
    pat_pkg::kind_t kind, logic [15:0] prog, logic [12:0] pid, logic [15:0] sid,
    logic [4:0] ver, logic [7:0] sn, logic [15:0] cnt, logic lst);
    pat_pkg::result_t r;
    r.kind           = kind;
    r.program_number = prog;
    r.map_pid        = pid;
    r.stream_id      = sid;
    r.version        = ver;
    r.section_number = sn;
    r.received_count = cnt;
    r.last           = lst;
    return r;
  endfunction

  always_comb begin
    active              = first_byte || (mode == MODE_ACTIVE);
    idx_c               = first_byte ? '0 : byte_index;
    tl_c                = first_byte ? '0 : total_length;
    stream_id_next      = first_byte ? '0 : stream_id;
    version_next        = first_byte ? '0 : version;
    section_number_next = first_byte ? '0 : section_number;
    entry_shift_next    = first_byte ? '0 : entry_shift;
    crc_shift_next      = first_byte ? '0 : crc_shift;
    total_length_next   = tl_c;
    byte_index_next     = byte_index;
    mode_next           = mode;
    accepted_count_next = accepted_count;
    entry_end           = ((tl_c - 13'd12) & ~13'd3) + 13'd8;
    slot_ok             = {1'b0, data_byte} < 9'(pat_pkg::SECTION_SLOTS);
    bad                 = 1'b0;
    done                = 1'b0;
    entry_hit           = 1'b0;
    tail_kind           = pat_pkg::KIND_INVALID;
    entry_prog          = entry_shift_next[23:8];
    entry_pid           = {entry_shift_next[4:0], data_byte};
    req.rd_en           = 1'b0;
    req.rd_slot         = data_byte[pat_pkg::SLOT_W-1:0];
    req.query_slot      = section_number_next[pat_pkg::SLOT_W-1:0];
    req.wr_en           = 1'b0;
    req.wr_slot         = section_number_next[pat_pkg::SLOT_W-1:0];
    req.wr_version      = version_next;
    req.wr_crc          = '0;
    if (fire && active) begin
      mode_next = MODE_ACTIVE;
      unique case (idx_c)
        POS_TABLE_ID: bad = (data_byte != expected_table_id);
        POS_LEN_HI:   total_length_next = {1'b0, data_byte[3:0], 8'd0};
        POS_LEN_LO: begin
          total_length_next = (tl_c | {5'd0, data_byte}) + 13'd3;
          bad = (total_length_next < 13'd12);
        end
        POS_SID_HI:   stream_id_next[15:8] = data_byte;
        POS_SID_LO:   stream_id_next[7:0] = data_byte;
        POS_VERSION:  version_next = data_byte[5:1];
        POS_SECTION: begin
          section_number_next = data_byte;
          bad = !slot_ok;
          req.rd_en = 1'b1;
        end
        POS_RESERVED: ;
        default: begin
          if (idx_c < entry_end) begin
            if (idx_c[1:0] != 2'd3) begin
              entry_shift_next = {entry_shift_next[15:0], data_byte};
            end else if (!rsp.present) begin
              entry_hit = 1'b1;
            end
          end
          if (idx_c >= tl_c - 13'd4) begin
            crc_shift_next = {crc_shift_next[23:0], data_byte};
          end
          if (idx_c == tl_c - 13'd1) begin
            done = 1'b1;
            if (!rsp.present) begin
              tail_kind           = pat_pkg::KIND_ACCEPTED;
              req.wr_en           = 1'b1;
              req.wr_crc          = crc_shift_next;
              accepted_count_next = accepted_count + 16'd1;
            end else if (rsp.version == version_next && rsp.crc == crc_shift_next) begin
              tail_kind = pat_pkg::KIND_REPEAT;
            end else begin
              tail_kind = pat_pkg::KIND_UPDATE;
            end
          end
        end
      endcase
      if (bad || done || last_byte) begin
        mode_next = MODE_IDLE;
      end else begin
        byte_index_next = idx_c + 13'd1;
      end
    end
    tail_valid = fire && active && (bad || done || last_byte);
    res_cnt    = {1'b0, entry_hit} + {1'b0, tail_valid};
    if (entry_hit) begin
      res0 = make_res(pat_pkg::KIND_ENTRY, entry_prog, entry_pid, stream_id_next,
                      version_next, section_number_next, accepted_count_next, !tail_valid);
    end else begin
      res0 = make_res(tail_kind, '0, '0, stream_id_next, version_next,
                      section_number_next, accepted_count_next, 1'b1);
    end
    res1 = make_res(tail_kind, '0, '0, stream_id_next, version_next,
                    section_number_next, accepted_count_next, 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_IDLE;
      expected_table_id <= '0;
      byte_index        <= '0;
      total_length      <= '0;
      stream_id         <= '0;
      version           <= '0;
      section_number    <= '0;
      entry_shift       <= '0;
      crc_shift         <= '0;
      accepted_count    <= '0;
    end else begin
      if (cfg.valid) begin
        expected_table_id <= cfg.data;
      end
      if (fire && active) begin
        mode           <= mode_next;
        byte_index     <= byte_index_next;
        total_length   <= total_length_next;
        stream_id      <= stream_id_next;
        version        <= version_next;
        section_number <= section_number_next;
        entry_shift    <= entry_shift_next;
        crc_shift      <= crc_shift_next;
        accepted_count <= accepted_count_next;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/pat_result_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pat_result_queue
// Four-deep result queue taking up to two results a cycle, draining one when taken.
// ----------------------------------------------------------------------------
module pat_result_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [1:0]       push_cnt,
  input  wire pat_pkg::result_t push0,
  input  wire pat_pkg::result_t push1,
  output logic                  room,
  pat_result_if.source          results
);

  pat_pkg::result_t slots [4];
  logic [1:0]       wr_ptr, rd_ptr;
  logic [2:0]       count;
  logic             pop;
  pat_pkg::result_t head;

  assign room = (count <= 3'd2);
  assign pop  = results.valid && results.ready;
  assign head = slots[rd_ptr];

  assign results.valid          = (count != 3'd0);
  assign results.kind           = head.kind;
  assign results.program_number = head.program_number;
  assign results.map_pid        = head.map_pid;
  assign results.stream_id      = head.stream_id;
  assign results.version        = head.version;
  assign results.section_number = head.section_number;
  assign results.received_count = head.received_count;
  assign results.last           = head.last;

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      slots[wr_ptr] <= push0;
    end
    if (push_cnt == 2'd2) begin
      slots[wr_ptr + 2'd1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_cnt;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {1'b0, push_cnt} - {2'd0, pop};
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/pat_section_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pat_section_parser
// Program association section parser, one section byte per request.
// ----------------------------------------------------------------------------
// A byte is taken every cycle unless stalled: it is registered, decoded and
// its zero, one or two results go into a four-deep result queue that drains
// one result per cycle when taken. The byte input stalls only while that queue
// holds more than two results, so sustained rate is one byte per cycle
// whenever results are taken as they appear. Presence flags are flops cleared
// by reset itself, so no clearing pass follows reset. Version and CRC of each
// section number live in a memory read at the section-number byte, and the
// write of expected_table_id is taken at any time with ready held high.
module pat_section_parser (
  input  wire logic    clk,
  input  wire logic    rst,
  pat_cfg_if.sink      cfg,
  pat_byte_if.sink     bytes,
  pat_result_if.source results
);

  logic                iv;
  logic [7:0]          idata;
  logic                ifirst;
  logic                ilast;
  logic                fire;
  logic                room;
  logic [1:0]          res_cnt;
  pat_pkg::result_t    res0, res1;
  pat_pkg::store_req_t req;
  pat_pkg::store_rsp_t rsp;

  assign fire        = iv && room;
  assign bytes.ready = !iv || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (bytes.ready) begin
      iv <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      idata  <= bytes.data_byte;
      ifirst <= bytes.first_byte;
      ilast  <= bytes.last_byte;
    end
  end

  pat_parse_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .fire       (fire),
    .data_byte  (idata),
    .first_byte (ifirst),
    .last_byte  (ilast),
    .req        (req),
    .rsp        (rsp),
    .res_cnt    (res_cnt),
    .res0       (res0),
    .res1       (res1)
  );

  pat_slot_store u_store (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  pat_result_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_cnt (res_cnt),
    .push0    (res0),
    .push1    (res1),
    .room     (room),
    .results  (results)
  );

endmodule
`default_nettype wire

FILE: bench/pat_section_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pat_section_checker
// Watches the register, byte and result channels of the section parser,
// works out the results of every accepted byte from its own copy of the
// parse state and section store, and compares each result taken from the
// block against the oldest one still awaited.
// ----------------------------------------------------------------------------
module pat_section_checker (
  input  logic  clk,
  input  logic  rst,
  pat_cfg_if    cfg,
  pat_byte_if   bytes,
  pat_result_if results,
  output int    fail_count,
  output int    outstanding
);

  logic                slot_used    [pat_pkg::SECTION_SLOTS];
  logic [4:0]          slot_version [pat_pkg::SECTION_SLOTS];
  logic [31:0]         slot_crc     [pat_pkg::SECTION_SLOTS];
  logic [7:0]          expect_tid;
  logic                in_section;
  logic [12:0]         byte_pos;
  int unsigned         section_len;
  logic [15:0]         stream_id;
  logic [4:0]          version;
  logic [7:0]          sect_no;
  logic [23:0]         entry_acc;
  logic [31:0]         crc_acc;
  logic [15:0]         sections_taken;
  pat_pkg::result_t    awaited_results[$];
  int                  reported;

  function automatic pat_pkg::result_t make_result(pat_pkg::kind_t kind, logic [15:0] prog,
                                                   logic [12:0] pid);
    pat_pkg::result_t r;
    r.kind           = kind;
    r.program_number = prog;
    r.map_pid        = pid;
    r.stream_id      = stream_id;
    r.version        = version;
    r.section_number = sect_no;
    r.received_count = sections_taken;
    r.last           = 1'b0;
    return r;
  endfunction

  task automatic parse_byte(input logic [7:0] d, input logic first, input logic fin);
    pat_pkg::result_t outs[$];
    pat_pkg::result_t r;
    int unsigned      i;
    int unsigned      nent;
    int unsigned      slot;
    logic             bad;
    logic             done;
    bad  = 1'b0;
    done = 1'b0;
    if (first) begin
      in_section  = 1'b1;
      byte_pos    = '0;
      section_len = 0;
      stream_id   = '0;
      version     = '0;
      sect_no     = '0;
      entry_acc   = '0;
      crc_acc     = '0;
    end else if (!in_section) begin
      return;
    end
    i = {19'd0, byte_pos};
    case (i)
      0: bad = (d != expect_tid);
      1: section_len = {20'd0, d[3:0], 8'h00};
      2: begin
        section_len = (section_len | {24'd0, d}) + 3;
        bad = (section_len < 12);
      end
      3: stream_id[15:8] = d;
      4: stream_id[7:0] = d;
      5: version = d[5:1];
      6: begin
        sect_no = d;
        bad = ({24'd0, d} >= pat_pkg::SECTION_SLOTS);
      end
      7: ;
      default: begin
        nent = (section_len - 12) / 4;
        slot = {24'd0, sect_no} % pat_pkg::SECTION_SLOTS;
        if (i < 8 + 4 * nent) begin
          if (((i - 8) & 3) < 3) begin
            entry_acc = {entry_acc[15:0], d};
          end else if (!slot_used[slot]) begin
            outs.push_back(make_result(pat_pkg::KIND_ENTRY, entry_acc[23:8],
                                       {entry_acc[4:0], d}));
          end
        end
        if (i >= section_len - 4) crc_acc = {crc_acc[23:0], d};
        if (i == section_len - 1) begin
          if (!slot_used[slot]) begin
            slot_used[slot]    = 1'b1;
            slot_version[slot] = version;
            slot_crc[slot]     = crc_acc;
            sections_taken     = sections_taken + 16'd1;
            outs.push_back(make_result(pat_pkg::KIND_ACCEPTED, '0, '0));
          end else if (slot_version[slot] == version && slot_crc[slot] == crc_acc) begin
            outs.push_back(make_result(pat_pkg::KIND_REPEAT, '0, '0));
          end else begin
            outs.push_back(make_result(pat_pkg::KIND_UPDATE, '0, '0));
          end
          done = 1'b1;
        end
      end
    endcase
    if (bad || (!done && fin)) begin
      outs.push_back(make_result(pat_pkg::KIND_INVALID, '0, '0));
      in_section = 1'b0;
    end else if (done) begin
      in_section = 1'b0;
    end else begin
      byte_pos = byte_pos + 13'd1;
    end
    if (outs.size() > 0) begin
      r = outs.pop_back();
      r.last = 1'b1;
      outs.push_back(r);
    end
    foreach (outs[k]) awaited_results.push_back(outs[k]);
  endtask

  task automatic check_result();
    pat_pkg::result_t want;
    logic             wrong;
    if (awaited_results.size() == 0) begin
      fail_count++;
      if (reported < 10) begin
        reported++;
        $display("%0t: result kind %0d with none awaited", $time, results.kind);
      end
      return;
    end
    want  = awaited_results.pop_front();
    wrong = (results.kind !== want.kind) ||
            (results.program_number !== want.program_number) ||
            (results.map_pid !== want.map_pid) ||
            (results.stream_id !== want.stream_id) ||
            (results.version !== want.version) ||
            (results.section_number !== want.section_number) ||
            (results.received_count !== want.received_count) ||
            (results.last !== want.last);
    if (wrong) begin
      fail_count++;
      if (reported < 10) begin
        reported++;
        $display("%0t: mismatch (expected/actual) kind %0d/%0d program %h/%h pid %h/%h",
                 $time, want.kind, results.kind, want.program_number,
                 results.program_number, want.map_pid, results.map_pid);
        $display("  stream %h/%h version %0d/%0d section %0d/%0d count %0d/%0d last %0d/%0d",
                 want.stream_id, results.stream_id, want.version, results.version,
                 want.section_number, results.section_number, want.received_count,
                 results.received_count, want.last, results.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (slot_used[k]) slot_used[k] = 1'b0;
      expect_tid     = '0;
      in_section     = 1'b0;
      byte_pos       = '0;
      section_len    = 0;
      stream_id      = '0;
      version        = '0;
      sect_no        = '0;
      entry_acc      = '0;
      crc_acc        = '0;
      sections_taken = '0;
      awaited_results.delete();
      reported       = 0;
      fail_count     = 0;
      outstanding    = 0;
    end else begin
      if (cfg.valid && cfg.ready) expect_tid = cfg.data;
      if (bytes.valid && bytes.ready) begin
        parse_byte(bytes.data_byte, bytes.first_byte, bytes.last_byte);
      end
      if (results.valid && results.ready) check_result();
      outstanding = awaited_results.size();
    end
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds program association sections to the parser byte by byte: a short
// directed run, then random well-formed, repeated and updated sections mixed
// with corrupt, cut, restarted and noise requests, under several table ids
// and random idling on both sides. The checker does the comparing.
// ----------------------------------------------------------------------------
module testbench;

  localparam int HOLD_CYCLES = 160;

  typedef enum {
    SEC_GOOD, SEC_FRESH, SEC_REPEAT, SEC_UPDATE, SEC_BAD_ID,
    SEC_SHORT, SEC_CUT, SEC_RESTART, SEC_LONG_CUT, SEC_NOISE
  } sec_flavour_t;

  logic        clk;
  logic        rst;
  int          fail_count;
  int          outstanding;
  logic [7:0]  cur_tid;
  logic [7:0]  sec_bytes[$];
  bit          known_have [pat_pkg::SECTION_SLOTS];
  logic [4:0]  known_ver  [pat_pkg::SECTION_SLOTS];
  logic [31:0] known_crc  [pat_pkg::SECTION_SLOTS];
  logic [7:0]  known_q[$];
  int          bytes_sent;
  int          src_gap_pct;
  int          sink_stall_pct;
  bit          hold_req;
  bit          hold_taken;

  pat_cfg_if    cfg_ch();
  pat_byte_if   byte_ch();
  pat_result_if result_ch();

  pat_section_parser u_top (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .bytes   (byte_ch),
    .results (result_ch)
  );

  pat_section_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_ch),
    .bytes       (byte_ch),
    .results     (result_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    hold_taken = 1'b0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (sink_stall_pct > 0 && $urandom_range(0, 99) < sink_stall_pct) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 7)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic first, input logic fin);
    if (src_gap_pct > 0 && $urandom_range(0, 99) < src_gap_pct) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    byte_ch.valid      <= 1'b1;
    byte_ch.data_byte  <= d;
    byte_ch.first_byte <= first;
    byte_ch.last_byte  <= fin;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_run(input int count, input bit with_last);
    for (int k = 0; k < count; k++) begin
      send_byte(sec_bytes[k], k == 0, with_last && k == count - 1);
    end
  endtask

  task automatic write_table_id(input logic [7:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    cur_tid = value;
  endtask

  task automatic settle();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic remember(input logic [7:0] sn, input logic [4:0] ver, input logic [31:0] crc);
    if (!known_have[sn]) begin
      known_have[sn] = 1'b1;
      known_ver[sn]  = ver;
      known_crc[sn]  = crc;
      known_q.push_back(sn);
    end
  endtask

  task automatic build_section(input logic [7:0] sn, input logic [4:0] ver,
                               input logic [31:0] crc, input int nent, input int spare);
    logic [11:0] len;
    logic [7:0]  r8;
    logic [15:0] stream;
    sec_bytes.delete();
    len    = 12'(12 + 4 * nent + spare - 3);
    r8     = 8'($urandom);
    stream = 16'($urandom);
    sec_bytes.push_back(cur_tid);
    sec_bytes.push_back({r8[7:4], len[11:8]});
    sec_bytes.push_back(len[7:0]);
    sec_bytes.push_back(stream[15:8]);
    sec_bytes.push_back(stream[7:0]);
    sec_bytes.push_back({r8[3:2], ver, r8[0]});
    sec_bytes.push_back(sn);
    repeat (1 + 4 * nent + spare) begin
      r8 = 8'($urandom);
      sec_bytes.push_back(r8);
    end
    for (int k = 24; k >= 0; k -= 8) sec_bytes.push_back(crc[k +: 8]);
  endtask

  task automatic send_section(input sec_flavour_t flavour, input int n_ent);
    logic [7:0]  sn;
    logic [7:0]  r8;
    logic [4:0]  ver;
    logic [4:0]  flip;
    logic [31:0] crc;
    int          nent;
    int          tail;
    sn   = 8'($urandom_range(0, 255));
    ver  = 5'($urandom_range(0, 31));
    crc  = $urandom;
    flip = 5'($urandom_range(1, 31));
    if (n_ent >= 0) nent = n_ent;
    else if ($urandom_range(0, 7) == 0) nent = $urandom_range(4, 24);
    else nent = $urandom_range(0, 3);
    case (flavour)
      SEC_REPEAT, SEC_UPDATE: begin
        sn  = known_q[$urandom_range(0, known_q.size() - 1)];
        ver = known_ver[sn];
        crc = known_crc[sn];
        if (flavour == SEC_UPDATE) begin
          if ($urandom_range(0, 1) == 1) ver = ver ^ flip;
          else crc = crc ^ (32'h1 << $urandom_range(0, 31));
        end
      end
      SEC_FRESH: begin
        while (known_have[sn]) sn = sn + 8'd1;
      end
      default: ;
    endcase
    build_section(sn, ver, crc, nent, $urandom_range(0, 3));
    case (flavour)
      SEC_BAD_ID: begin
        r8 = 8'($urandom_range(1, 255));
        sec_bytes[0] = cur_tid ^ r8;
        send_run($urandom_range(1, 4), 1'($urandom_range(0, 1)));
      end
      SEC_SHORT: begin
        r8 = sec_bytes[1];
        sec_bytes[1] = r8 & 8'hF0;
        r8 = 8'($urandom_range(0, 8));
        sec_bytes[2] = r8;
        send_run($urandom_range(3, 5), 1'($urandom_range(0, 1)));
      end
      SEC_CUT: send_run($urandom_range(1, sec_bytes.size() - 1), 1'b1);
      SEC_RESTART: send_run($urandom_range(1, sec_bytes.size() - 1), 1'b0);
      SEC_LONG_CUT: begin
        r8 = sec_bytes[1];
        sec_bytes[1] = r8 | 8'h0F;
        sec_bytes[2] = 8'hFF;
        send_run($urandom_range(8, sec_bytes.size()), 1'b1);
      end
      SEC_NOISE: begin
        repeat ($urandom_range(1, 6)) begin
          r8 = 8'($urandom);
          send_byte(r8, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
        end
      end
      default: begin
        tail = $urandom_range(0, 3);
        if (tail == 1) begin
          repeat ($urandom_range(1, 3)) begin
            r8 = 8'($urandom);
            sec_bytes.push_back(r8);
          end
        end
        send_run(sec_bytes.size(), tail != 0);
        remember(sn, ver, crc);
      end
    endcase
  endtask

  function automatic sec_flavour_t pick_flavour();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return SEC_GOOD;
    if (r < 65) begin
      if (known_q.size() == 0) return SEC_GOOD;
      return (r < 57) ? SEC_REPEAT : SEC_UPDATE;
    end
    if (r < 71) return SEC_BAD_ID;
    if (r < 77) return SEC_SHORT;
    if (r < 87) return SEC_CUT;
    if (r < 93) return SEC_RESTART;
    if (r < 95) return SEC_LONG_CUT;
    return SEC_NOISE;
  endfunction

  task automatic run_phase(input int target, input int gap_pct, input int stall_pct);
    src_gap_pct    = gap_pct;
    sink_stall_pct = stall_pct;
    while (bytes_sent < target) send_section(pick_flavour(), -1);
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.data        <= '0;
    byte_ch.valid      <= 1'b0;
    byte_ch.data_byte  <= '0;
    byte_ch.first_byte <= 1'b0;
    byte_ch.last_byte  <= 1'b0;
    cur_tid        = '0;
    hold_req       = 1'b0;
    src_gap_pct    = 0;
    sink_stall_pct = 0;
    bytes_sent     = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    write_table_id(8'h00);
    send_byte(8'hA5, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hF0, 1'b0, 1'b0);
    send_byte(8'h08, 1'b0, 1'b0);
    build_section(8'hFF, 5'h1F, 32'hFFFF_FFFF, 1, 0);
    for (int k = 3; k < 12; k++) sec_bytes[k] = 8'hFF;
    send_run(sec_bytes.size(), 1'b1);
    remember(8'hFF, 5'h1F, 32'hFFFF_FFFF);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h0D, 1'b0, 1'b1);

    settle();
    write_table_id(8'hFF);
    run_phase(350, 10, 10);

    settle();
    write_table_id(8'($urandom_range(1, 254)));
    hold_req = 1'b1;
    send_section(SEC_FRESH, 24);
    run_phase(700, 5, 20);

    settle();
    write_table_id(8'h00);
    run_phase(1100, 25, 30);

    settle();
    write_table_id(8'($urandom));
    run_phase(1550, 0, 0);

    settle();
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
